/* hw/rtl/ism_pkg.sv */
package ism_pkg;

  localparam int unsigned DataW           = 64;
  localparam int unsigned IterW           = $clog2(DataW);
  localparam int unsigned CountW          = 7;
  localparam int unsigned StackDepthDflt  = 64;

  typedef enum logic [3:0] {
    CMD_PUSH  = 4'd0,
    CMD_POP   = 4'd1,
    CMD_ADD   = 4'd2,
    CMD_SUB   = 4'd3,
    CMD_MUL   = 4'd4,
    CMD_DIV   = 4'd5,
    CMD_PRINT = 4'd6,
    CMD_HALT  = 4'd7
  } cmd_e;

  typedef struct packed {
    logic [3:0]              command;
    logic signed [DataW-1:0] operand_value;
    logic                    program_end;
  } ism_in_req_t;

  typedef struct packed {
    logic                    print_valid;
    logic signed [DataW-1:0] print_value;
    logic [CountW-1:0]       stack_count;
    logic                    halted;
  } ism_out_req_t;

endpackage

/* hw/rtl/ism_ram.sv */
module ism_ram #(
  parameter int unsigned Width = 64,
  parameter int unsigned Depth = 64,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* hw/rtl/integer_stack_machine_top.sv */
// A request is decoded first; push, pop, halt and no-op then finish, print reads the top
// entry, add and sub read both operands for one adder pass, and mul and div take 64 steps
// of the shared 65-bit adder; div by zero skips them. Throughput: one request at a time,
// taken in idle. The stack sits in one single-port-read RAM; operands come out one per cycle.
// Reset (async, active low) clears stack pointer, halt flag, sequencer and output valid;
// stack contents are undefined until pushed.
module integer_stack_machine_top import ism_pkg::*; #(
  parameter int unsigned STACK_DEPTH = StackDepthDflt
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         in_valid_i,
  output logic         in_ready_o,
  input  ism_in_req_t  in_req_i,
  output logic         out_valid_o,
  input  logic         out_ready_i,
  output ism_out_req_t out_req_o
);

  localparam int unsigned AddrW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int unsigned SpW   = $clog2(STACK_DEPTH + 1);

  typedef enum logic [12:0] {
    ST_IDLE    = 13'b0000000000001,
    ST_DECODE  = 13'b0000000000010,
    ST_RD_P    = 13'b0000000000100,
    ST_RD_B    = 13'b0000000001000,
    ST_RD_A    = 13'b0000000010000,
    ST_ALU     = 13'b0000000100000,
    ST_MUL     = 13'b0000001000000,
    ST_DIV_NA  = 13'b0000010000000,
    ST_DIV_NB  = 13'b0000100000000,
    ST_DIV     = 13'b0001000000000,
    ST_DIV_FIX = 13'b0010000000000,
    ST_WB      = 13'b0100000000000,
    ST_DONE    = 13'b1000000000000
  } state_e;

  state_e             state_q, state_d;
  ism_in_req_t        req_q, req_d;
  logic [SpW-1:0]     sp_q, sp_d;
  logic               halt_q, halt_d;
  logic [DataW-1:0]   x_q, x_d, y_q, y_d, acc_q, acc_d, pv_q, pv_d;
  logic               pvalid_q, pvalid_d, neg_q, neg_d;
  logic [IterW-1:0]   cnt_q, cnt_d;
  logic               out_valid_q, out_valid_d;
  ism_out_req_t       out_q, out_d;

  logic               ram_we, ram_re;
  logic [AddrW-1:0]   ram_waddr, ram_raddr;
  logic [DataW-1:0]   ram_wdata, ram_rdata;

  logic [DataW-1:0]   add_x, add_y;
  logic               add_cin;
  logic [DataW:0]     sum;
  logic [DataW-1:0]   shifted;
  logic               is_sub, iter_last, out_free;
  logic [AddrW-1:0]   addr_top, addr_next;

  ism_ram #(
    .Width (DataW),
    .Depth (STACK_DEPTH)
  ) u_stack (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign sum       = {1'b0, add_x} + {1'b0, add_y} + (DataW + 1)'(add_cin);
  assign shifted   = {acc_q[DataW-2:0], x_q[DataW-1]};
  assign is_sub    = (req_q.command == CMD_SUB);
  assign iter_last = (cnt_q == IterW'(DataW - 1));
  assign out_free  = !out_valid_q || out_ready_i;
  assign addr_top  = AddrW'(sp_q - SpW'(1));
  assign addr_next = AddrW'(sp_q - SpW'(2));

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_req_o   = out_q;

  // shared adder operand select
  always_comb begin
    add_x   = '0;
    add_y   = '0;
    add_cin = 1'b0;
    unique case (state_q)
      ST_ALU: begin
        add_x   = x_q;
        add_y   = is_sub ? ~y_q : y_q;
        add_cin = is_sub;
      end
      ST_MUL: begin
        add_x = acc_q;
        add_y = x_q;
      end
      ST_DIV_NA: begin
        add_y   = ~x_q;
        add_cin = 1'b1;
      end
      ST_DIV_NB: begin
        add_y   = ~y_q;
        add_cin = 1'b1;
      end
      ST_DIV: begin
        add_x   = shifted;
        add_y   = ~y_q;
        add_cin = 1'b1;
      end
      ST_DIV_FIX: begin
        add_x   = neg_q ? '0 : x_q;
        add_y   = neg_q ? ~x_q : '0;
        add_cin = neg_q;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    state_d     = state_q;
    req_d       = req_q;
    sp_d        = sp_q;
    halt_d      = halt_q;
    x_d         = x_q;
    y_d         = y_q;
    acc_d       = acc_q;
    pv_d        = pv_q;
    pvalid_d    = pvalid_q;
    neg_d       = neg_q;
    cnt_d       = cnt_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !out_ready_i;
    ram_we      = 1'b0;
    ram_waddr   = AddrW'(sp_q);
    ram_wdata   = req_q.operand_value;
    ram_re      = 1'b0;
    ram_raddr   = addr_top;

    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          req_d   = in_req_i;
          state_d = ST_DECODE;
        end
      end
      ST_DECODE: begin
        pvalid_d = 1'b0;
        pv_d     = '0;
        state_d  = ST_DONE;
        if (!halt_q) begin
          unique case (req_q.command) inside
            CMD_PUSH: begin
              if (sp_q < SpW'(STACK_DEPTH)) begin
                ram_we = 1'b1;
                sp_d   = sp_q + SpW'(1);
              end
            end
            CMD_POP: begin
              if (sp_q != '0) begin
                sp_d = sp_q - SpW'(1);
              end
            end
            CMD_ADD, CMD_SUB, CMD_MUL, CMD_DIV: begin
              if (sp_q >= SpW'(2)) begin
                ram_re  = 1'b1;
                state_d = ST_RD_B;
              end
            end
            CMD_PRINT: begin
              if (sp_q != '0) begin
                ram_re  = 1'b1;
                state_d = ST_RD_P;
              end
            end
            CMD_HALT: begin
              halt_d = 1'b1;
            end
            default: begin
            end
          endcase
        end
      end
      ST_RD_P: begin
        pvalid_d = 1'b1;
        pv_d     = ram_rdata;
        state_d  = ST_DONE;
      end
      ST_RD_B: begin
        y_d       = ram_rdata;
        ram_re    = 1'b1;
        ram_raddr = addr_next;
        state_d   = ST_RD_A;
      end
      ST_RD_A: begin
        x_d   = ram_rdata;
        acc_d = '0;
        cnt_d = '0;
        neg_d = ram_rdata[DataW-1] ^ y_q[DataW-1];
        unique case (req_q.command)
          CMD_MUL: state_d = ST_MUL;
          CMD_DIV: state_d = (y_q == '0) ? ST_WB : ST_DIV_NA;
          default: state_d = ST_ALU;
        endcase
      end
      ST_ALU: begin
        acc_d   = sum[DataW-1:0];
        state_d = ST_WB;
      end
      ST_MUL: begin
        if (y_q[0]) begin
          acc_d = sum[DataW-1:0];
        end
        x_d   = {x_q[DataW-2:0], 1'b0};
        y_d   = {1'b0, y_q[DataW-1:1]};
        cnt_d = cnt_q + IterW'(1);
        if (iter_last) begin
          state_d = ST_WB;
        end
      end
      ST_DIV_NA: begin
        if (x_q[DataW-1]) begin
          x_d = sum[DataW-1:0];
        end
        state_d = ST_DIV_NB;
      end
      ST_DIV_NB: begin
        if (y_q[DataW-1]) begin
          y_d = sum[DataW-1:0];
        end
        acc_d   = '0;
        cnt_d   = '0;
        state_d = ST_DIV;
      end
      ST_DIV: begin
        acc_d = sum[DataW] ? sum[DataW-1:0] : shifted;
        x_d   = {x_q[DataW-2:0], sum[DataW]};
        cnt_d = cnt_q + IterW'(1);
        if (iter_last) begin
          state_d = ST_DIV_FIX;
        end
      end
      ST_DIV_FIX: begin
        acc_d   = sum[DataW-1:0];
        state_d = ST_WB;
      end
      ST_WB: begin
        ram_we    = 1'b1;
        ram_waddr = addr_next;
        ram_wdata = acc_q;
        sp_d      = sp_q - SpW'(1);
        state_d   = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) begin
          out_d.print_valid = pvalid_q;
          out_d.print_value = pv_q;
          out_d.stack_count = CountW'(sp_q);
          out_d.halted      = halt_q;
          out_valid_d       = 1'b1;
          if (req_q.program_end) begin
            sp_d   = '0;
            halt_d = 1'b0;
          end
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      sp_q        <= '0;
      halt_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      sp_q        <= sp_d;
      halt_q      <= halt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q    <= req_d;
    x_q      <= x_d;
    y_q      <= y_d;
    acc_q    <= acc_d;
    pv_q     <= pv_d;
    pvalid_q <= pvalid_d;
    neg_q    <= neg_d;
    cnt_q    <= cnt_d;
    out_q    <= out_d;
  end

  a_state_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(state_q))
    else $error("sequencer state not one-hot");

  a_sp_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sp_q <= SpW'(STACK_DEPTH))
    else $error("stack pointer beyond depth");

  a_accept_decode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> state_q == ST_DECODE)
    else $error("accepted request not decoded");

  a_halt_skips: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_DECODE && halt_q |=> state_q == ST_DONE && $stable(sp_q))
    else $error("instruction executed while halted");

  a_wb_pops: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_WB |=> sp_q == $past(sp_q) - SpW'(1))
    else $error("binary operation did not drop one entry");

endmodule
